FILE: src/atrk_pkg.sv
// Package: shared types and codes for the allocation tracking table.
`default_nettype none
package atrk_pkg;
  localparam int KEY_W   = 48;
  localparam int SIZE_W  = 32;
  localparam int TOT_W   = 40;
  localparam int CNT_W   = 9;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEAK   = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_NULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  localparam logic [2:0] ACT_NOP    = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_RESIZE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  localparam logic [2:0] ACT_PEAK   = 3'd5;
  localparam logic [2:0] ACT_NULL   = 3'd6;

  typedef struct packed {
    logic [KEY_W-1:0]  cmp_key;
    logic [KEY_W-1:0]  wr_key;
    logic [SIZE_W-1:0] wr_size;
    logic              cmp_en;
    logic              clear;
    logic              append;
    logic              erase;
    logic              rewrite;
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: src/atrk_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface atrk_in_if import atrk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  new_key;
  logic [SIZE_W-1:0] size;
  modport source(output valid, op, key, new_key, size, input ready);
  modport sink(input valid, op, key, new_key, size, output ready);
endinterface

interface atrk_out_if import atrk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [TOT_W-1:0] current_total;
  logic [TOT_W-1:0] peak_total;
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] count_at_peak;
  modport source(output valid, status, current_total, peak_total, live_count,
                 count_at_peak, input ready);
  modport sink(input valid, status, current_total, peak_total, live_count,
               count_at_peak, output ready);
endinterface
`default_nettype wire

FILE: src/atrk_cell.sv
// Table cell: one entry, key compare, append and shift-from-neighbor on erase.
`default_nettype none
module atrk_cell import atrk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctl_t         ctl,
  input  wire logic              prev_valid,
  input  wire logic              next_valid,
  input  wire logic [KEY_W-1:0]  next_key,
  input  wire logic [SIZE_W-1:0] next_size,
  input  wire logic              sel,
  input  wire logic              after,
  output      logic              valid,
  output      logic [KEY_W-1:0]  key,
  output      logic [SIZE_W-1:0] size,
  output      logic              match
);
  logic              valid_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] size_r;
  logic              match_r;
  logic              app_here;

  assign app_here = ctl.append && !valid_r && prev_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (app_here) begin
      valid_r <= 1'b1;
    end else if (ctl.erase && after) begin
      valid_r <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (app_here || (ctl.rewrite && sel)) begin
      key_r  <= ctl.wr_key;
      size_r <= ctl.wr_size;
    end else if (ctl.erase && after) begin
      key_r  <= next_key;
      size_r <= next_size;
    end
    if (ctl.cmp_en) begin
      match_r <= valid_r && (key_r == ctl.cmp_key);
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign size  = size_r;
  assign match = match_r;
endmodule
`default_nettype wire

FILE: src/allocation_tracking_table.sv
// Allocation tracking table: top level with cell row, sequencer and totals.
//
// Usage: one request word on in_ch (op, key, new_key, size) gives exactly one
// result word on out_ch (status, totals, counts). Entries live in a row of
// cells kept packed in insertion order; an erase shifts later cells down by
// one toward the front in the same update.
// Steps: once a request is accepted, the result is built by compare,
// first-match select, size read and update. in_ch.ready is high only in
// the idle state, so a new request is not taken until the update step of
// the current one is done.
// The result sits in an output register; a new request is accepted while it
// waits. If out_ch stalls, the update step holds until the output register
// is free, and the next request waits behind it.
// Reset (rst_n low, synchronous): all entries invalid, totals and counts
// zero, no result pending.
`default_nettype none
module allocation_tracking_table import atrk_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input wire logic   clk,
  input wire logic   rst_n,
  atrk_in_if.sink    in_ch,
  atrk_out_if.source out_ch
);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        act_r, act_nxt;
  logic [KEY_W-1:0]  cmp_key_r, cmp_key_nxt;
  logic [KEY_W-1:0]  wr_key_r, wr_key_nxt;
  logic [SIZE_W-1:0] size_r;

  logic [ENTRIES-1:0] valid_w, match_w, sel_r, after_r;
  logic [ENTRIES-1:0] sel_nxt, after_nxt;
  logic               seen;
  logic [KEY_W-1:0]   key_w  [ENTRIES];
  logic [SIZE_W-1:0]  sizes_w[ENTRIES];
  logic               found_r;
  logic [SIZE_W-1:0]  old_r, old_nxt;

  logic [TOT_W-1:0] total_r, total_nxt, peak_r, peak_nxt;
  logic [CW-1:0]    count_r, count_nxt, pcount_r, pcount_nxt;
  logic [ST_W-1:0]  st_nxt;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_st_r;
  logic [TOT_W-1:0] out_tot_r, out_peak_r;
  logic [CW-1:0]    out_cnt_r, out_pcnt_r;

  logic      accept, go;
  cell_ctl_t ctl;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign go          = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);

  always_comb begin
    act_nxt     = ACT_NOP;
    cmp_key_nxt = in_ch.key;
    wr_key_nxt  = in_ch.key;
    case (in_ch.op)
      OP_ADD:    act_nxt = (in_ch.key == '0) ? ACT_NULL : ACT_ADD;
      OP_REMOVE: act_nxt = (in_ch.key == '0) ? ACT_NULL : ACT_REMOVE;
      OP_RESIZE: begin
        wr_key_nxt = in_ch.new_key;
        if (in_ch.new_key == '0) begin
          act_nxt = (in_ch.key == '0) ? ACT_NULL : ACT_REMOVE;
        end else if (in_ch.key == '0) begin
          act_nxt = ACT_ADD;
        end else begin
          act_nxt = ACT_RESIZE;
        end
      end
      OP_CLEAR:  act_nxt = ACT_CLEAR;
      OP_PEAK:   act_nxt = ACT_PEAK;
      default:   act_nxt = ACT_NOP;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_SEL;
      S_SEL:   state_nxt = S_READ;
      S_READ:  state_nxt = S_APPLY;
      S_APPLY: if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // oldest match and every cell from it toward the back
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_nxt[i]   = match_w[i] && !seen;
      after_nxt[i] = match_w[i] || seen;
      seen         = after_nxt[i];
    end
  end

  always_comb begin
    old_nxt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      old_nxt = old_nxt | (sizes_w[i] & {SIZE_W{sel_r[i]}});
    end
  end

  always_comb begin
    ctl         = '0;
    ctl.cmp_key = cmp_key_r;
    ctl.wr_key  = wr_key_r;
    ctl.wr_size = size_r;
    ctl.cmp_en  = (state_r == S_MATCH);
    total_nxt   = total_r;
    peak_nxt    = peak_r;
    count_nxt   = count_r;
    pcount_nxt  = pcount_r;
    st_nxt      = ST_DONE;
    case (act_r)
      ACT_ADD: begin
        if (count_r >= CW'(ENTRIES)) begin
          st_nxt = ST_FULL;
        end else begin
          ctl.append = go;
          total_nxt  = total_r + TOT_W'(size_r);
          count_nxt  = count_r + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (!found_r) begin
          st_nxt = ST_MISSING;
        end else begin
          ctl.erase = go;
          total_nxt = total_r - TOT_W'(old_r);
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_RESIZE: begin
        if (!found_r) begin
          st_nxt = ST_MISSING;
        end else if (size_r == '0) begin
          ctl.erase = go;
          total_nxt = total_r - TOT_W'(old_r);
          count_nxt = count_r - CW'(1);
        end else begin
          ctl.rewrite = go;
          total_nxt   = total_r - TOT_W'(old_r) + TOT_W'(size_r);
        end
      end
      ACT_CLEAR: begin
        ctl.clear  = go;
        total_nxt  = '0;
        peak_nxt   = '0;
        count_nxt  = '0;
        pcount_nxt = '0;
      end
      ACT_PEAK: begin
        peak_nxt   = total_r;
        pcount_nxt = count_r;
      end
      ACT_NULL: st_nxt = ST_NULL;
      default:  st_nxt = ST_DONE;
    endcase
    if ((act_r == ACT_ADD || act_r == ACT_RESIZE) && st_nxt == ST_DONE
        && !(act_r == ACT_RESIZE && size_r == '0) && total_nxt > peak_r) begin
      peak_nxt   = total_nxt;
      pcount_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      pcount_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
        total_r     <= total_nxt;
        peak_r      <= peak_nxt;
        count_r     <= count_nxt;
        pcount_r    <= pcount_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= act_nxt;
      cmp_key_r <= cmp_key_nxt;
      wr_key_r  <= wr_key_nxt;
      size_r    <= in_ch.size;
    end
    if (state_r == S_SEL) begin
      sel_r   <= sel_nxt;
      after_r <= after_nxt;
      found_r <= |match_w;
    end
    if (state_r == S_READ) begin
      old_r <= old_nxt;
    end
    if (go) begin
      out_st_r   <= st_nxt;
      out_tot_r  <= total_nxt;
      out_peak_r <= peak_nxt;
      out_cnt_r  <= count_nxt;
      out_pcnt_r <= pcount_nxt;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic              pv, nv;
    logic [KEY_W-1:0]  nk;
    logic [SIZE_W-1:0] ns;
    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_mid
      assign pv = valid_w[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign nv = 1'b0;
      assign nk = key_w[i];
      assign ns = sizes_w[i];
    end else begin : g_inner
      assign nv = valid_w[i+1];
      assign nk = key_w[i+1];
      assign ns = sizes_w[i+1];
    end
    atrk_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_valid(pv),
      .next_valid(nv),
      .next_key  (nk),
      .next_size (ns),
      .sel       (sel_r[i]),
      .after     (after_r[i]),
      .valid     (valid_w[i]),
      .key       (key_w[i]),
      .size      (sizes_w[i]),
      .match     (match_w[i])
    );
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.current_total = out_tot_r;
  assign out_ch.peak_total    = out_peak_r;
  assign out_ch.live_count    = CNT_W'(out_cnt_r);
  assign out_ch.count_at_peak = CNT_W'(out_pcnt_r);
endmodule
`default_nettype wire

FILE: src/atrk_chk.sv
// Checker: port-level properties of the allocation tracking table, with bind.
`default_nettype none
module atrk_chk import atrk_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ST_W-1:0]  status,
  input wire logic [TOT_W-1:0] current_total,
  input wire logic [TOT_W-1:0] peak_total,
  input wire logic [CNT_W-1:0] live_count,
  input wire logic [CNT_W-1:0] count_at_peak
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_peak_ge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> peak_total >= current_total)
    else $error("peak below current total");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL) |-> live_count != '0)
    else $error("full status with empty table");
endmodule

bind allocation_tracking_table atrk_chk u_atrk_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .current_total(out_ch.current_total),
  .peak_total   (out_ch.peak_total),
  .live_count   (out_ch.live_count),
  .count_at_peak(out_ch.count_at_peak)
);
`default_nettype wire
